// ===== design/drum_hit_onset_detector_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the drum hit onset detector
// Concurrent checks with a synchronous active-low reset as disable.
// ---------------------------------------------------------------------------
`ifndef DRUM_HIT_ONSET_DETECTOR_MACROS_SVH
`define DRUM_HIT_ONSET_DETECTOR_MACROS_SVH

// same-cycle implication
`define DHOD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DHOD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dhod_pkg.sv =====
// ---------------------------------------------------------------------------
// dhod_pkg
// Shared widths, constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package dhod_pkg;

    // default parameter values
    localparam int DEF_PLAYERS    = 2;
    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_WINDOW     = 8;
    localparam int DEF_LOCKOUT_US = 20000;

    // field widths
    localparam int PLAYER_W  = 1;
    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 12;
    localparam int KNOB_W    = 12;
    localparam int TIME_W    = 32;
    localparam int HIT_W     = 3;

    // threshold register file
    localparam int                NREGS     = 8;
    localparam int                THR_W     = 17;
    localparam int                THR_IDX_W = $clog2(NREGS);
    localparam logic [THR_W-1:0]  THR_RESET = 17'd2000;
    localparam int                DATA_W    = 32;
    localparam int                REG_LSB   = 2;
    localparam int                PADDR_W   = THR_IDX_W + REG_LSB;

    // gain polynomial, Q2.14, with d = knob - 2048:
    // gain = (3*2^34 + 3*2^23*d + 3*2^11*d^2 + d^3) / (3*2^20)
    localparam int                   KNOB_MID   = 2048;
    localparam int                   D_W        = KNOB_W + 1;
    localparam int                   DSQ_W      = 24;
    localparam int                   DCUBE_W    = 35;
    localparam int                   NUM_W      = 39;
    localparam logic signed [NUM_W-1:0] GAIN_K0 = 39'sd51539607552;
    localparam int                   NUM_FRAC   = 20;
    localparam int                   NUMHI_W    = 17;
    // exact floor(n/3) for n < 2^17: (n * ceil(2^18/3)) >> 18
    localparam int                   DIV3_RECIP = 87382;
    localparam int                   RECIP_W    = 17;
    localparam int                   DIV3_SHIFT = 18;
    localparam int                   GAIN_W     = 16;
    localparam int                   GAIN_FRAC  = 14;
    localparam int                   SCALED_W   = 14;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cube;
        logic sum;
        logic div;
        logic scale;
        logic commit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_range;
        logic out_busy;
    } sts_t;

endpackage

// ===== design/dhod_regs.sv =====
// ---------------------------------------------------------------------------
// dhod_regs
// APB-style threshold register file, one 17-bit threshold per channel.
// ---------------------------------------------------------------------------
module dhod_regs (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [dhod_pkg::PADDR_W-1:0]                 paddr,
    input  logic [dhod_pkg::DATA_W-1:0]                  pwdata,
    output logic [dhod_pkg::DATA_W-1:0]                  prdata,
    output logic                                         pready,
    output logic [dhod_pkg::NREGS-1:0][dhod_pkg::THR_W-1:0] thr
);
    import dhod_pkg::*;

    logic [NREGS-1:0][THR_W-1:0] thr_reg;
    logic [THR_IDX_W-1:0]        reg_sel;
    logic                        wr_en;

    assign reg_sel = paddr[REG_LSB +: THR_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NREGS; i++) begin
                thr_reg[i] <= THR_RESET;
            end
        end else if (wr_en) begin
            thr_reg[reg_sel] <= pwdata[THR_W-1:0];
        end
    end

    // read back
    assign prdata = DATA_W'(thr_reg[reg_sel]);
    assign thr    = thr_reg;

endmodule

// ===== design/dhod_ctrl.sv =====
// ---------------------------------------------------------------------------
// dhod_ctrl
// Sequencer stepping one sample through gain, scaling and the hit decision.
// ---------------------------------------------------------------------------
module dhod_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dhod_pkg::sts_t sts,
    output dhod_pkg::cmd_t cmd
);
    import dhod_pkg::*;

    localparam int              STATE_W   = 3;
    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] ST_CUBE   = 3'd1;
    localparam logic [STATE_W-1:0] ST_SUM    = 3'd2;
    localparam logic [STATE_W-1:0] ST_DIV    = 3'd3;
    localparam logic [STATE_W-1:0] ST_SCALE  = 3'd4;
    localparam logic [STATE_W-1:0] ST_UPDATE = 3'd5;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic               accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = accept;
                // out-of-range beats are dropped here
                if (accept && sts.in_range) begin
                    state_next = ST_CUBE;
                end
            end
            ST_CUBE: begin
                cmd.cube   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the result register is free
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/dhod_datapath.sv =====
// ---------------------------------------------------------------------------
// dhod_datapath
// Gain polynomial, sample scaling, per-channel moving sum and lockout state.
// ---------------------------------------------------------------------------
module dhod_datapath #(
    parameter int PLAYERS    = dhod_pkg::DEF_PLAYERS,
    parameter int CHANNELS   = dhod_pkg::DEF_CHANNELS,
    parameter int WINDOW     = dhod_pkg::DEF_WINDOW,
    parameter int LOCKOUT_US = dhod_pkg::DEF_LOCKOUT_US
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  dhod_pkg::cmd_t                               cmd,
    output dhod_pkg::sts_t                               sts,
    input  logic [dhod_pkg::PLAYER_W-1:0]                s_player,
    input  logic [dhod_pkg::CHANNEL_W-1:0]               s_channel,
    input  logic [dhod_pkg::SAMPLE_W-1:0]                s_sample,
    input  logic [dhod_pkg::KNOB_W-1:0]                  s_knob,
    input  logic [dhod_pkg::TIME_W-1:0]                  s_now_us,
    input  logic [dhod_pkg::NREGS-1:0][dhod_pkg::THR_W-1:0] thr,
    input  logic                                         m_ready,
    output logic                                         m_valid,
    output logic [dhod_pkg::HIT_W-1:0]                   m_hit_code
);
    import dhod_pkg::*;

    localparam int NCH    = PLAYERS * CHANNELS;
    localparam int IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PLR_W  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DEPTH  = NCH * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = SCALED_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);

    // item registers
    logic [PLR_W-1:0]          plr_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [SAMPLE_W-1:0]       smp_reg;
    logic [TIME_W-1:0]         now_reg;
    logic signed [D_W-1:0]     d_reg;
    logic signed [DSQ_W-1:0]   dsq_reg;
    logic signed [DCUBE_W-1:0] dcube_reg;
    logic [NUMHI_W-1:0]        numhi_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic [SCALED_W-1:0]       scaled_reg;
    logic [SCALED_W-1:0]       rd_reg;

    // per-channel and per-player state
    logic [PTR_W-1:0]   ptr_reg   [NCH];
    logic [NCH-1:0]     wrap_reg;
    logic [SUM_W-1:0]   sum_reg   [NCH];
    logic [SUM_W-1:0]   prev_reg  [NCH];
    logic [PLAYERS-1:0] locked_reg;
    logic [TIME_W-1:0]  start_reg [PLAYERS];

    // window ring store, all channels
    logic [SCALED_W-1:0] win_mem [DEPTH];

    logic m_valid_reg;
    logic [HIT_W-1:0] m_code_reg;

    // intermediate logic
    logic signed [D_W-1:0]            d_in;
    logic signed [2*D_W-1:0]          sq_full;
    logic signed [DSQ_W+D_W-1:0]      cube_full;
    logic signed [NUM_W-1:0]          d_ext;
    logic signed [NUM_W-1:0]          sq_ext;
    logic signed [NUM_W-1:0]          cu_ext;
    logic signed [NUM_W-1:0]          num;
    logic [NUMHI_W+RECIP_W-1:0]       qprod;
    logic [SAMPLE_W+GAIN_W-1:0]       sprod;
    logic [ADDR_W-1:0]                addr;
    logic [SCALED_W-1:0]              oldv;
    logic [SUM_W-1:0]                 power;
    logic [TIME_W-1:0]                elapsed;
    logic                             released;
    logic                             unlocked;
    logic [THR_IDX_W-1:0]             thr_idx;
    logic                             hit;
    logic [31:0]                      idx_full;
    logic [PTR_W-1:0]                 ptr_cur;

    // status
    assign sts.in_range = (32'(s_player) < PLAYERS) && (32'(s_channel) < CHANNELS);
    assign sts.out_busy = m_valid_reg && !m_ready;

    // gain polynomial terms
    assign d_in      = $signed({1'b0, s_knob}) - D_W'(KNOB_MID);
    assign sq_full   = (2*D_W)'(d_in) * (2*D_W)'(d_in);
    assign cube_full = (DSQ_W+D_W)'(dsq_reg) * (DSQ_W+D_W)'(d_reg);
    assign d_ext     = NUM_W'(d_reg);
    assign sq_ext    = NUM_W'(dsq_reg);
    assign cu_ext    = NUM_W'(dcube_reg);
    // 3*2^23*d and 3*2^11*d^2 as shift pairs
    assign num = GAIN_K0 + (d_ext <<< 24) + (d_ext <<< 23)
               + (sq_ext <<< 12) + (sq_ext <<< 11) + cu_ext;
    assign qprod = (NUMHI_W+RECIP_W)'(numhi_reg) * (NUMHI_W+RECIP_W)'(DIV3_RECIP);
    assign sprod = (SAMPLE_W+GAIN_W)'(smp_reg) * (SAMPLE_W+GAIN_W)'(gain_reg);

    // ring address of this channel's slot
    assign ptr_cur = ptr_reg[idx_reg];
    assign addr    = ADDR_W'(32'(idx_reg) * WINDOW + 32'(ptr_cur));

    // moving sum and hit decision
    assign oldv     = wrap_reg[idx_reg] ? rd_reg : '0;
    assign power    = sum_reg[idx_reg] - SUM_W'(oldv) + SUM_W'(scaled_reg);
    assign elapsed  = now_reg - start_reg[plr_reg];
    assign released = (elapsed >= TIME_W'(LOCKOUT_US));
    assign unlocked = !locked_reg[plr_reg] || released;
    assign thr_idx  = (32'(idx_reg) < NREGS) ? THR_IDX_W'(idx_reg) : THR_IDX_W'(NREGS - 1);
    assign hit      = unlocked && (power > prev_reg[idx_reg])
                   && (32'(power) >= 32'(thr[thr_idx]));
    assign idx_full = 32'(idx_reg);

    // arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            plr_reg <= PLR_W'(s_player);
            idx_reg <= IDX_W'(32'(s_player) * CHANNELS + 32'(s_channel));
            smp_reg <= s_sample;
            now_reg <= s_now_us;
            d_reg   <= d_in;
            dsq_reg <= sq_full[DSQ_W-1:0];
        end
        if (cmd.cube) begin
            dcube_reg <= cube_full[DCUBE_W-1:0];
        end
        if (cmd.sum) begin
            numhi_reg <= num[NUM_FRAC +: NUMHI_W];
        end
        if (cmd.div) begin
            gain_reg <= qprod[DIV3_SHIFT +: GAIN_W];
        end
        if (cmd.scale) begin
            scaled_reg <= sprod[GAIN_FRAC +: SCALED_W];
        end
    end

    // window store: read outgoing entry, write newest on commit
    always_ff @(posedge aclk) begin
        if (cmd.cube) begin
            rd_reg <= win_mem[addr];
        end
        if (cmd.commit) begin
            win_mem[addr] <= scaled_reg;
        end
    end

    // channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= '0;
            for (int i = 0; i < NCH; i++) begin
                ptr_reg[i]  <= '0;
                sum_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            sum_reg[idx_reg]  <= power;
            prev_reg[idx_reg] <= power;
            if (32'(ptr_cur) + 1 >= WINDOW) begin
                ptr_reg[idx_reg]  <= '0;
                wrap_reg[idx_reg] <= 1'b1;
            end else begin
                ptr_reg[idx_reg] <= ptr_cur + PTR_W'(1);
            end
        end
    end

    // player lockout
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg <= '0;
        end else if (cmd.commit) begin
            if (hit) begin
                locked_reg[plr_reg] <= 1'b1;
            end else if (released) begin
                locked_reg[plr_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && hit) begin
            start_reg[plr_reg] <= now_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit && hit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && hit) begin
            m_code_reg <= idx_full[HIT_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit_code = m_code_reg;

endmodule

// ===== design/drum_hit_onset_detector.sv =====
// Path: the sequencer loads and squares an accepted sample, then walks the gain
// multiplier chain (cube, sum, divide by three, scale); the update step waits
// while a held result is unread, registers any hit onto m_valid, and only then
// takes a new sample. Out-of-range player/channel beats are dropped in idle.
// Reset (aresetn, synchronous): windows, sums and lockouts clear at once,
// thresholds return to 2000; no clearing pass, a per-channel fill flag.
// ---------------------------------------------------------------------------
// drum_hit_onset_detector
// Moving-sum onset detector with per-player lockout and APB thresholds.
// ---------------------------------------------------------------------------
`include "drum_hit_onset_detector_macros.svh"

module drum_hit_onset_detector #(
    parameter int PLAYERS    = dhod_pkg::DEF_PLAYERS,
    parameter int CHANNELS   = dhod_pkg::DEF_CHANNELS,
    parameter int WINDOW     = dhod_pkg::DEF_WINDOW,
    parameter int LOCKOUT_US = dhod_pkg::DEF_LOCKOUT_US
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dhod_pkg::PLAYER_W-1:0]   s_player,
    input  logic [dhod_pkg::CHANNEL_W-1:0]  s_channel,
    input  logic [dhod_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic [dhod_pkg::KNOB_W-1:0]     s_knob,
    input  logic [dhod_pkg::TIME_W-1:0]     s_now_us,
    // hit channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dhod_pkg::HIT_W-1:0]      m_hit_code,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dhod_pkg::PADDR_W-1:0]    paddr,
    input  logic [dhod_pkg::DATA_W-1:0]     pwdata,
    output logic [dhod_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import dhod_pkg::*;

    cmd_t                        cmd;
    sts_t                        sts;
    logic [NREGS-1:0][THR_W-1:0] thr;

    dhod_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    dhod_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dhod_datapath #(
        .PLAYERS    (PLAYERS),
        .CHANNELS   (CHANNELS),
        .WINDOW     (WINDOW),
        .LOCKOUT_US (LOCKOUT_US)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_player   (s_player),
        .s_channel  (s_channel),
        .s_sample   (s_sample),
        .s_knob     (s_knob),
        .s_now_us   (s_now_us),
        .thr        (thr),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_hit_code (m_hit_code)
    );

    // checks
    `DHOD_ASSERT_IMPLY(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd), "overlapping commands")
    `DHOD_ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, cmd.commit, !m_valid || m_ready, "result lost")
    `DHOD_ASSERT_IMPLY(a_result_src, aclk, aresetn, $rose(m_valid), !$past(s_ready), "stray result")
    `DHOD_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready && sts.in_range, !s_ready, "ready while busy")

endmodule

// ===== test/drum_hit_onset_detector_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// drum_hit_onset_detector_tb
// Self-checking bench. Sample beats from a queue go in over valid/ready; an
// in-bench copy of the gain, moving sum and lockout logic works out the hit
// beats due, and the monitor checks each hit beat in order. Thresholds are
// set over APB between phases and read back.
// ---------------------------------------------------------------------------
module drum_hit_onset_detector_tb;
    import dhod_pkg::*;

    localparam int     PLAYERS       = DEF_PLAYERS;
    localparam int     CHANNELS      = DEF_CHANNELS;
    localparam int     WINDOW        = DEF_WINDOW;
    localparam int     LOCKOUT_US    = DEF_LOCKOUT_US;
    localparam int     NCH           = PLAYERS * CHANNELS;
    localparam longint GAIN_DEN      = 3145728;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     DRAIN_LIMIT   = 60000;
    localparam int     LONG_HOLD     = 600;
    localparam int     MAX_REPORTS   = 10;
    localparam int     FRAMES        = 56;

    // threshold programming styles, one per phase
    typedef enum int {
        LEVELS_MID,
        LEVELS_EXTREME,
        LEVELS_WIDE,
        LEVELS_ONE
    } level_mode_t;

    typedef struct {
        logic [PLAYER_W-1:0]  player;
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  reading;
        logic [KNOB_W-1:0]    knob;
        logic [TIME_W-1:0]    now_us;
    } sample_beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [PLAYER_W-1:0]  s_player  = '0;
    logic [CHANNEL_W-1:0] s_channel = '0;
    logic [SAMPLE_W-1:0]  s_sample  = '0;
    logic [KNOB_W-1:0]    s_knob    = '0;
    logic [TIME_W-1:0]    s_now_us  = '0;
    logic                 m_ready   = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]    pwdata    = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic [HIT_W-1:0]     m_hit_code;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    drum_hit_onset_detector #(
        .PLAYERS    (PLAYERS),
        .CHANNELS   (CHANNELS),
        .WINDOW     (WINDOW),
        .LOCKOUT_US (LOCKOUT_US)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_player   (s_player),
        .s_channel  (s_channel),
        .s_sample   (s_sample),
        .s_knob     (s_knob),
        .s_now_us   (s_now_us),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit_code (m_hit_code),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 aclk = ~aclk;

    // detector state as the bench sees it
    logic [SCALED_W-1:0] ring_mem [NCH][WINDOW];
    int unsigned         ring_pos [NCH];
    logic [THR_W-1:0]    power_now [NCH];
    logic [THR_W-1:0]    power_last [NCH];
    logic                player_locked [PLAYERS];
    logic [TIME_W-1:0]   lock_time [PLAYERS];
    logic [THR_W-1:0]    hit_level [NREGS];

    sample_beat_t        samples_to_send [$];
    logic [HIT_W-1:0]    hits_due [$];
    int                  mismatches   = 0;
    logic                sample_taken = 1'b0;
    bit                  no_gaps      = 1'b0;
    int                  hold_asks    = 0;
    int                  holds_served = 0;
    int                  hold_left    = 0;

    // stimulus shaping
    logic [TIME_W-1:0]   clock_us = 32'hFFFC_0000;
    int unsigned         envelope [NCH];
    logic [KNOB_W-1:0]   knob_setting [NCH];

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Q2.14 gain 1 + x + x^2/2 + x^3/6, x = knob/2048 - 1, floored
    function automatic logic [GAIN_W-1:0] knob_gain(input logic [KNOB_W-1:0] knob);
        longint d;
        longint num;
        d   = longint'(knob) - KNOB_MID;
        num = GAIN_DEN * 16384 + 8 * GAIN_DEN * d + 6144 * d * d + d * d * d;
        return GAIN_W'(num / GAIN_DEN);
    endfunction

    // one accepted sample: update window, power and lockout, queue any hit
    function automatic void detect_hit(input sample_beat_t b);
        int unsigned           ch;
        int unsigned           pos;
        logic [TIME_W-1:0]     elapsed;
        logic [SAMPLE_W+GAIN_W-1:0] prod;
        logic [SCALED_W-1:0]   scaled;
        logic [SCALED_W-1:0]   outgoing;
        logic [THR_W-1:0]      pwr;
        bit                    hit;
        // player or channel beyond the configured counts: dropped
        if (int'(b.player) >= PLAYERS || int'(b.channel) >= CHANNELS)
            return;
        elapsed = b.now_us - lock_time[b.player];
        if (player_locked[b.player] && elapsed >= TIME_W'(LOCKOUT_US))
            player_locked[b.player] = 1'b0;
        ch       = int'(b.player) * CHANNELS + int'(b.channel);
        pos      = ring_pos[ch];
        prod     = (SAMPLE_W+GAIN_W)'(b.reading) * (SAMPLE_W+GAIN_W)'(knob_gain(b.knob));
        scaled   = prod[SAMPLE_W+GAIN_W-1:GAIN_FRAC];
        outgoing = ring_mem[ch][pos];
        ring_mem[ch][pos] = scaled;
        ring_pos[ch] = (pos + 1 >= WINDOW) ? 0 : pos + 1;
        pwr = power_now[ch] - THR_W'(outgoing) + THR_W'(scaled);
        power_now[ch] = pwr;
        // channels past the register file share the last threshold
        hit = !player_locked[b.player] && pwr > power_last[ch]
              && pwr >= hit_level[(ch < NREGS) ? ch : NREGS - 1];
        power_last[ch] = pwr;
        if (hit) begin
            player_locked[b.player] = 1'b1;
            lock_time[b.player]     = b.now_us;
            hits_due.push_back(HIT_W'(ch));
        end
    endfunction

    // accepted sample beats feed the detector copy
    always @(posedge aclk) begin
        sample_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            detect_hit('{s_player, s_channel, s_sample, s_knob, s_now_us});
    end

    // sample driver: new beat only once the last one went through
    always @(negedge aclk) begin : sample_driver
        sample_beat_t nb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sample_taken) begin
            if (samples_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 20)) begin
                nb = samples_to_send.pop_front();
                s_valid   <= 1'b1;
                s_player  <= nb.player;
                s_channel <= nb.channel;
                s_sample  <= nb.reading;
                s_knob    <= nb.knob;
                s_now_us  <= nb.now_us;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // hit receiver: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != holds_served) begin
            holds_served <= hold_asks;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= no_gaps || ($urandom_range(99) >= 20);
        end
    end

    // hit monitor
    always @(posedge aclk) begin : hit_monitor
        logic [HIT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (hits_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected hit beat, code %0d", m_hit_code));
            end else begin
                want = hits_due.pop_front();
                if (m_hit_code !== want)
                    flag_mismatch($sformatf("hit code: expected %0d, got %0d",
                                            want, m_hit_code));
            end
        end
    end

    function automatic void queue_beat(input int p, input int c, input int s, input int k,
                                       input logic [TIME_W-1:0] t);
        sample_beat_t b;
        b.player  = PLAYER_W'(p);
        b.channel = CHANNEL_W'(c);
        b.reading = SAMPLE_W'(s);
        b.knob    = KNOB_W'(k);
        b.now_us  = t;
        samples_to_send.push_back(b);
    endfunction

    // frames of samples sharing a timestamp, with strikes that decay
    task automatic queue_frames(input int frames, input int max_step, input int strike_pct);
        sample_beat_t b;
        int unsigned  lvl;
        for (int ch = 0; ch < NCH; ch++)
            knob_setting[ch] = KNOB_W'($urandom_range(4095));
        for (int f = 0; f < frames; f++) begin
            clock_us += $urandom_range(max_step, 1);
            for (int ch = 0; ch < NCH; ch++) begin
                // stray beat with every field random
                if ($urandom_range(99) < 3) begin
                    b.player  = PLAYER_W'($urandom);
                    b.channel = CHANNEL_W'($urandom);
                    b.reading = SAMPLE_W'($urandom);
                    b.knob    = KNOB_W'($urandom);
                    b.now_us  = $urandom;
                    samples_to_send.push_back(b);
                end
                if ($urandom_range(99) < 15)
                    continue;
                if ($urandom_range(99) < 2)
                    knob_setting[ch] = KNOB_W'($urandom_range(4095));
                if (envelope[ch] == 0 && $urandom_range(99) < strike_pct)
                    envelope[ch] = $urandom_range(4095, 1200);
                lvl = envelope[ch] + $urandom_range(120);
                if (lvl > 4095)
                    lvl = 4095;
                queue_beat(ch / CHANNELS, ch % CHANNELS, lvl, int'(knob_setting[ch]),
                           clock_us);
                envelope[ch] = envelope[ch] * $urandom_range(85, 40) / 100;
                if (envelope[ch] < 60)
                    envelope[ch] = 0;
            end
        end
    endtask

    task automatic apb_write(input int idx, input logic [DATA_W-1:0] word);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx << REG_LSB);
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        hit_level[idx] = word[THR_W-1:0];
    endtask

    task automatic apb_read_check(input int idx);
        logic [DATA_W-1:0] got;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'(idx << REG_LSB);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== DATA_W'(hit_level[idx]))
            flag_mismatch($sformatf("threshold %0d readback: expected %0d, got %0d",
                                    idx, hit_level[idx], got));
    endtask

    task automatic program_levels(input level_mode_t mode);
        logic [DATA_W-1:0] word;
        for (int i = 0; i < NREGS; i++) begin
            case (mode)
                LEVELS_MID: begin
                    word = $urandom_range(30000, 500);
                end
                LEVELS_EXTREME: begin
                    // junk above the register width must be dropped
                    word = $urandom;
                    word[THR_W-1:0] = (i % 2 != 0) ? '1 : '0;
                end
                LEVELS_WIDE: begin
                    word = (i < NREGS / 2) ? $urandom_range(131071) : $urandom_range(5000);
                end
                default: begin
                    word = 1;
                end
            endcase
            apb_write(i, word);
        end
        for (int i = 0; i < NREGS; i++)
            apb_read_check(i);
        @(posedge aclk);
    endtask

    // wait for all beats out and all hits back, then let the pipe empty
    task automatic drain_hits();
        int waited;
        waited = 0;
        while ((samples_to_send.size() != 0 || s_valid || hits_due.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (hits_due.size() != 0) begin
            flag_mismatch($sformatf("%0d hit beats never arrived", hits_due.size()));
            hits_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : run_phases
        logic [TIME_W-1:0] t0;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int w = 0; w < WINDOW; w++)
                ring_mem[ch][w] = '0;
            ring_pos[ch]   = 0;
            power_now[ch]  = '0;
            power_last[ch] = '0;
            envelope[ch]   = 0;
        end
        for (int p = 0; p < PLAYERS; p++) begin
            player_locked[p] = 1'b0;
            lock_time[p]     = '0;
        end
        for (int i = 0; i < NREGS; i++)
            hit_level[i] = THR_RESET;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values first
        for (int i = 0; i < NREGS; i++)
            apb_read_check(i);
        @(posedge aclk);

        // directed: extremes, lockout across the timestamp wrap, ring wrap,
        // equal power twice in a row
        t0 = 32'hFFFF_F000;
        queue_beat(0, 0, 4095, 4095, t0);
        queue_beat(0, 1, 4095, 4095, t0);
        queue_beat(1, 3, 4095, 0, t0);
        queue_beat(1, 3, 4095, 0, t0);
        queue_beat(1, 2, 0, 2048, t0);
        queue_beat(0, 0, 0, 0, t0 + 19999);
        queue_beat(0, 0, 4095, 2048, t0 + 20000);
        for (int j = 0; j < 10; j++)
            queue_beat(1, 1, (j < WINDOW) ? 500 * (j + 1) : 0, 2048, t0 + 40000);
        queue_beat(0, 2, 0, 2047, 32'h0000_0000);
        queue_beat(0, 3, 1, 1, 32'hFFFF_FFFF);
        queue_beat(1, 0, 2730, 2730, 32'h5555_5555);
        queue_beat(1, 0, 1365, 1365, 32'hAAAA_AAAA);
        queue_beat(0, 1, 0, 2048, t0 + 60000);
        queue_beat(0, 1, 0, 2048, t0 + 60000);
        drain_hits();

        // reset thresholds
        queue_frames(FRAMES, 4000, 12);
        drain_hits();

        // mid thresholds, both sides flat out
        program_levels(LEVELS_MID);
        no_gaps = 1'b1;
        queue_frames(FRAMES, 4000, 12);
        drain_hits();
        no_gaps = 1'b0;

        // zero and full-scale thresholds, frame steps that can outlast the lockout, receiver
        // holds off so the block backs up
        program_levels(LEVELS_EXTREME);
        queue_frames(FRAMES, 30000, 25);
        hold_asks++;
        drain_hits();

        program_levels(LEVELS_WIDE);
        queue_frames(FRAMES, 6000, 15);
        drain_hits();

        program_levels(LEVELS_ONE);
        queue_frames(FRAMES, 2500, 10);
        drain_hits();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== drum_hit_onset_detector.f =====
+incdir+design
design/dhod_pkg.sv
design/dhod_regs.sv
design/dhod_ctrl.sv
design/dhod_datapath.sv
design/drum_hit_onset_detector.sv
test/drum_hit_onset_detector_tb.sv
